>>> rtl/core/llp_pkg.sv
// Shared types, constants and the cosine table for the lidar packet parser.
// No dependencies; used by every module of the block.
package llp_pkg;

  // Packet framing
  localparam logic [7:0] START_BYTE  = 8'hFA;
  localparam logic [7:0] INDEX_FIRST = 8'hA0;
  localparam logic [7:0] INDEX_LAST  = 8'hF9;
  localparam int         BODY_LEN    = 20;
  localparam int         COUNT_W     = $clog2(BODY_LEN);
  localparam int         LAST_WORD_LO = 17;  // final folded word ends here
  localparam int         CHK_W       = 15;
  localparam int         ACC_W       = 26;

  // Front sector geometry
  localparam int SECTOR_HALF = 36;
  localparam int FRONT_SLOTS = 72;
  localparam int LAST_ANGLE  = 359;
  localparam int COS_ENTRIES = 90;

  // q / 10 as (q * DIV10_MUL) >> DIV10_SHIFT, exact for 14-bit q
  localparam logic [15:0] DIV10_MUL   = 16'd52429;
  localparam int          DIV10_SHIFT = 19;

  localparam int QUEUE_DEPTH = 2;

  // One checked packet, handed from the front end to the back end
  typedef struct packed {
    logic [6:0]       number;
    logic [15:0]      speed;
    logic [15:0][7:0] rd;      // reading bytes, reading k at 4k..4k+3
    logic             ok;
    logic [15:0]      errors;
  } pkt_t;

  // floor(cos(d deg) * 65536), Q1.16
  function automatic logic [16:0] cos_q16(input logic [6:0] d);
    logic [16:0] c;
    unique case (d)
      7'd0: c = 17'd65536;  7'd1: c = 17'd65526;  7'd2: c = 17'd65496;
      7'd3: c = 17'd65446;  7'd4: c = 17'd65376;  7'd5: c = 17'd65286;
      7'd6: c = 17'd65176;  7'd7: c = 17'd65047;  7'd8: c = 17'd64898;
      7'd9: c = 17'd64729;  7'd10: c = 17'd64540; 7'd11: c = 17'd64331;
      7'd12: c = 17'd64103; 7'd13: c = 17'd63856; 7'd14: c = 17'd63589;
      7'd15: c = 17'd63302; 7'd16: c = 17'd62997; 7'd17: c = 17'd62672;
      7'd18: c = 17'd62328; 7'd19: c = 17'd61965; 7'd20: c = 17'd61583;
      7'd21: c = 17'd61183; 7'd22: c = 17'd60763; 7'd23: c = 17'd60326;
      7'd24: c = 17'd59870; 7'd25: c = 17'd59395; 7'd26: c = 17'd58903;
      7'd27: c = 17'd58393; 7'd28: c = 17'd57864; 7'd29: c = 17'd57319;
      7'd30: c = 17'd56755; 7'd31: c = 17'd56175; 7'd32: c = 17'd55577;
      7'd33: c = 17'd54963; 7'd34: c = 17'd54331; 7'd35: c = 17'd53683;
      7'd36: c = 17'd53019; 7'd37: c = 17'd52339; 7'd38: c = 17'd51643;
      7'd39: c = 17'd50931; 7'd40: c = 17'd50203; 7'd41: c = 17'd49460;
      7'd42: c = 17'd48702; 7'd43: c = 17'd47929; 7'd44: c = 17'd47142;
      7'd45: c = 17'd46340; 7'd46: c = 17'd45525; 7'd47: c = 17'd44695;
      7'd48: c = 17'd43852; 7'd49: c = 17'd42995; 7'd50: c = 17'd42125;
      7'd51: c = 17'd41243; 7'd52: c = 17'd40347; 7'd53: c = 17'd39440;
      7'd54: c = 17'd38521; 7'd55: c = 17'd37589; 7'd56: c = 17'd36647;
      7'd57: c = 17'd35693; 7'd58: c = 17'd34728; 7'd59: c = 17'd33753;
      7'd60: c = 17'd32768; 7'd61: c = 17'd31772; 7'd62: c = 17'd30767;
      7'd63: c = 17'd29752; 7'd64: c = 17'd28729; 7'd65: c = 17'd27696;
      7'd66: c = 17'd26655; 7'd67: c = 17'd25606; 7'd68: c = 17'd24550;
      7'd69: c = 17'd23486; 7'd70: c = 17'd22414; 7'd71: c = 17'd21336;
      7'd72: c = 17'd20251; 7'd73: c = 17'd19160; 7'd74: c = 17'd18064;
      7'd75: c = 17'd16961; 7'd76: c = 17'd15854; 7'd77: c = 17'd14742;
      7'd78: c = 17'd13625; 7'd79: c = 17'd12504; 7'd80: c = 17'd11380;
      7'd81: c = 17'd10252; 7'd82: c = 17'd9120;  7'd83: c = 17'd7986;
      7'd84: c = 17'd6850;  7'd85: c = 17'd5711;  7'd86: c = 17'd4571;
      7'd87: c = 17'd3429;  7'd88: c = 17'd2287;  7'd89: c = 17'd1143;
      default: c = 17'd0;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/core/llp_front.sv
// Front end: byte framing, packet body capture and running checksum fold.
// Depends on llp_pkg; pushes one pkt_t per completed packet.
module llp_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          take,
  input  logic [7:0]    in_byte,
  output logic          pkt_push,
  output llp_pkg::pkt_t pkt
);

  localparam logic [1:0] SYNC_HUNT  = 2'd0;
  localparam logic [1:0] SYNC_INDEX = 2'd1;
  localparam logic [1:0] SYNC_BODY  = 2'd2;

  logic [1:0]                  sync;
  logic [6:0]                  number;
  logic [llp_pkg::COUNT_W-1:0] count;
  logic [7:0]                  store [llp_pkg::BODY_LEN-1];
  logic [7:0]                  lo;
  logic [llp_pkg::ACC_W-1:0]   acc;
  logic [llp_pkg::ACC_W-1:0]   acc_next;
  logic [llp_pkg::CHK_W-1:0]   chk;
  logic [15:0]                 chk_fold;
  logic [15:0]                 failures;
  logic [15:0]                 failures_next;
  logic                        last_byte;
  logic                        match;

  assign acc_next = {acc[llp_pkg::ACC_W-2:0], 1'b0}
                  + llp_pkg::ACC_W'({in_byte, lo});
  assign chk_fold = 16'(acc_next[llp_pkg::CHK_W-1:0])
                  + 16'(acc_next[llp_pkg::ACC_W-1:llp_pkg::CHK_W]);

  assign last_byte = take && (sync == SYNC_BODY)
                  && (count == llp_pkg::COUNT_W'(llp_pkg::BODY_LEN - 1));
  // received checksum word: high byte arriving now, low byte held in lo
  assign match = ({1'b0, chk} == {in_byte, lo});
  assign failures_next = (failures == 16'hFFFF) ? failures : failures + 16'd1;

  assign pkt_push = last_byte;

  always_comb begin
    pkt.number = number;
    pkt.speed  = {store[1], store[0]};
    for (int i = 0; i < 16; i++) begin
      pkt.rd[i] = store[i + 2];
    end
    pkt.ok     = match;
    pkt.errors = match ? failures : failures_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sync     <= SYNC_HUNT;
      number   <= '0;
      count    <= '0;
      failures <= '0;
    end else if (take) begin
      unique case (sync)
        SYNC_HUNT: begin
          if (in_byte == llp_pkg::START_BYTE) sync <= SYNC_INDEX;
        end
        SYNC_INDEX: begin
          if (in_byte >= llp_pkg::INDEX_FIRST && in_byte <= llp_pkg::INDEX_LAST) begin
            number <= 7'(in_byte - llp_pkg::INDEX_FIRST);
            count  <= '0;
            sync   <= SYNC_BODY;
          end else if (in_byte != llp_pkg::START_BYTE) begin
            sync <= SYNC_HUNT;
          end
        end
        SYNC_BODY: begin
          if (last_byte) begin
            count <= '0;
            sync  <= SYNC_HUNT;
            if (!match) failures <= failures_next;
          end else begin
            count <= count + 1'b1;
          end
        end
        default: sync <= SYNC_HUNT;
      endcase
    end
  end

  // Datapath: body store, word low byte and the fold accumulator
  always_ff @(posedge clk) begin
    if (take) begin
      if (sync == SYNC_INDEX) begin
        acc <= llp_pkg::ACC_W'({in_byte, llp_pkg::START_BYTE});
      end
      if (sync == SYNC_BODY) begin
        if (count != llp_pkg::COUNT_W'(llp_pkg::BODY_LEN - 1)) store[count] <= in_byte;
        if (!count[0]) begin
          lo <= in_byte;
        end else if (count <= llp_pkg::COUNT_W'(llp_pkg::LAST_WORD_LO)) begin
          acc <= acc_next;
          if (count == llp_pkg::COUNT_W'(llp_pkg::LAST_WORD_LO)) begin
            chk <= chk_fold[llp_pkg::CHK_W-1:0];
          end
        end
      end
    end
  end

endmodule

>>> rtl/core/llp_queue.sv
// Two-entry packet queue between front and back ends.
// Depends on llp_pkg for pkt_t and the depth.
module llp_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  llp_pkg::pkt_t wr_pkt,
  output logic          q_full,
  input  logic          rd,
  output logic          q_valid,
  output llp_pkg::pkt_t rd_pkt
);

  localparam int PTR_W = $clog2(llp_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(llp_pkg::QUEUE_DEPTH + 1);

  llp_pkg::pkt_t    slots [llp_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wp;
  logic [PTR_W-1:0] rp;
  logic [CNT_W-1:0] fill;

  assign q_full  = (fill == CNT_W'(llp_pkg::QUEUE_DEPTH));
  assign q_valid = (fill != '0);
  assign rd_pkt  = slots[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      rp   <= '0;
      fill <= '0;
    end else begin
      if (wr) wp <= (wp == PTR_W'(llp_pkg::QUEUE_DEPTH - 1)) ? '0 : wp + 1'b1;
      if (rd) rp <= (rp == PTR_W'(llp_pkg::QUEUE_DEPTH - 1)) ? '0 : rp + 1'b1;
      if (wr && !rd) fill <= fill + 1'b1;
      else if (rd && !wr) fill <= fill - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) slots[wp] <= wr_pkt;
  end

endmodule

>>> rtl/core/llp_back.sv
// Back end: expands a queued packet into results, with front-sector
// projection over two stages (cosine multiply, then divide by ten).
// Depends on llp_pkg.
module llp_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  llp_pkg::pkt_t head,
  output logic          q_pop,
  output logic          empty,
  input  logic          pop,
  output logic [8:0]    reading_angle,
  output logic [13:0]   distance_mm,
  output logic [15:0]   signal_quality,
  output logic          invalid_flag,
  output logic          strength_warning,
  output logic          front_valid,
  output logic [6:0]    front_slot,
  output logic [10:0]   front_cm,
  output logic [15:0]   motor_speed,
  output logic          checksum_ok,
  output logic [15:0]   error_total,
  output logic          last_of_packet
);

  typedef struct packed {
    logic [8:0]  angle;
    logic [13:0] distance;
    logic [15:0] quality;
    logic        inval;
    logic        warn;
    logic        fvalid;
    logic [6:0]  slot;
    logic [15:0] speed;
    logic        ok;
    logic [15:0] errors;
    logic        last;
  } res_t;

  logic [1:0]  k;
  logic        v1, v2, adv1, adv2, take;
  res_t        r1, r2, r_new;
  logic [13:0] q1, q_new;
  logic [10:0] cm2;
  logic [29:0] div_prod;

  // reading k fields
  logic [7:0]  b0, b1, b2, b3;
  logic [8:0]  angle;
  logic [8:0]  slot_w;
  logic [6:0]  off;
  logic        front;
  logic        fvalid;
  logic [30:0] prod;

  assign adv2  = !v2 || pop;
  assign adv1  = !v1 || adv2;
  assign take  = adv1 && q_valid;
  assign q_pop = take && (!head.ok || k == 2'd3);
  assign empty = !v2;

  always_comb begin
    b0    = head.rd[{k, 2'd0}];
    b1    = head.rd[{k, 2'd1}];
    b2    = head.rd[{k, 2'd2}];
    b3    = head.rd[{k, 2'd3}];
    angle = {head.number, k};
    front  = 1'b0;
    slot_w = '0;
    off    = '0;
    if (angle < 9'(llp_pkg::SECTOR_HALF)) begin
      front  = 1'b1;
      slot_w = 9'(llp_pkg::SECTOR_HALF - 1) - angle;
      off    = 7'(angle);
    end else if (angle > 9'(llp_pkg::LAST_ANGLE - llp_pkg::SECTOR_HALF)) begin
      front  = 1'b1;
      slot_w = 9'(llp_pkg::SECTOR_HALF + llp_pkg::LAST_ANGLE) - angle;
      off    = 7'(9'(llp_pkg::LAST_ANGLE) - angle);
    end
    fvalid = front && !b1[7] && (slot_w < 9'(llp_pkg::FRONT_SLOTS))
          && (off < 7'(llp_pkg::COS_ENTRIES));
    prod   = 31'({b1[5:0], b0}) * 31'(llp_pkg::cos_q16(off));

    r_new.angle    = angle;
    r_new.distance = {b1[5:0], b0};
    r_new.quality  = {b3, b2};
    r_new.inval    = b1[7];
    r_new.warn     = b1[6];
    r_new.fvalid   = fvalid;
    r_new.slot     = fvalid ? slot_w[6:0] : 7'd0;
    r_new.speed    = head.speed;
    r_new.ok       = 1'b1;
    r_new.errors   = head.errors;
    r_new.last     = (k == 2'd3);
    q_new          = fvalid ? prod[29:16] : 14'd0;

    // checksum failure: a single result, reading fields cleared
    if (!head.ok) begin
      r_new        = '0;
      r_new.speed  = head.speed;
      r_new.errors = head.errors;
      r_new.last   = 1'b1;
      q_new        = '0;
    end
  end

  assign div_prod = 30'(q1) * 30'(llp_pkg::DIV10_MUL);
  assign cm2      = div_prod[llp_pkg::DIV10_SHIFT +: 11];

  always_ff @(posedge clk) begin
    if (rst) begin
      k  <= '0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (take) k <= q_pop ? 2'd0 : k + 2'd1;
      if (adv1) v1 <= q_valid;
      if (adv2) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      r1 <= r_new;
      q1 <= q_new;
    end
    if (adv2 && v1) begin
      r2       <= r1;
      front_cm <= cm2;
    end
  end

  assign reading_angle    = r2.angle;
  assign distance_mm      = r2.distance;
  assign signal_quality   = r2.quality;
  assign invalid_flag     = r2.inval;
  assign strength_warning = r2.warn;
  assign front_valid      = r2.fvalid;
  assign front_slot       = r2.slot;
  assign motor_speed      = r2.speed;
  assign checksum_ok      = r2.ok;
  assign error_total      = r2.errors;
  assign last_of_packet   = r2.last;

endmodule

>>> rtl/core/lidar_packet_parser.sv
// Lidar packet parser: one serial byte per request in, up to four
// readings per 22-byte packet out. A byte is taken every clock while the
// two-entry packet queue has room; a good packet gives four results and a
// checksum failure one, and results reach the output through the packet
// queue and the back end's result registers r1 and r2. The back end works
// through a good packet well inside the 22 bytes of the next one, so
// with results taken promptly the input runs at one byte per cycle and only
// stalls once held-back results fill the queue. No pass is needed after
// reset.
// Depends on llp_pkg, llp_front, llp_queue and llp_back.
module lidar_packet_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte,
  output logic        empty,
  input  logic        pop,
  output logic [8:0]  reading_angle,
  output logic [13:0] distance_mm,
  output logic [15:0] signal_quality,
  output logic        invalid_flag,
  output logic        strength_warning,
  output logic        front_valid,
  output logic [6:0]  front_slot,
  output logic [10:0] front_cm,
  output logic [15:0] motor_speed,
  output logic        checksum_ok,
  output logic [15:0] error_total,
  output logic        last_of_packet
);

  logic          take;
  logic          pkt_push;
  llp_pkg::pkt_t pkt;
  logic          q_valid;
  logic          q_pop;
  llp_pkg::pkt_t head;

  assign take = push && !full;

  llp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .in_byte  (in_byte),
    .pkt_push (pkt_push),
    .pkt      (pkt)
  );

  llp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (pkt_push),
    .wr_pkt  (pkt),
    .q_full  (full),
    .rd      (q_pop),
    .q_valid (q_valid),
    .rd_pkt  (head)
  );

  llp_back u_back (
    .clk              (clk),
    .rst              (rst),
    .q_valid          (q_valid),
    .head             (head),
    .q_pop            (q_pop),
    .empty            (empty),
    .pop              (pop),
    .reading_angle    (reading_angle),
    .distance_mm      (distance_mm),
    .signal_quality   (signal_quality),
    .invalid_flag     (invalid_flag),
    .strength_warning (strength_warning),
    .front_valid      (front_valid),
    .front_slot       (front_slot),
    .front_cm         (front_cm),
    .motor_speed      (motor_speed),
    .checksum_ok      (checksum_ok),
    .error_total      (error_total),
    .last_of_packet   (last_of_packet)
  );

endmodule
